// ----- src/fpsr_pkg.sv -----
// Package for the fixed pattern stream replace block.
// Field widths, item mode codes and the hit counter limit.
// No dependencies.
package fpsr_pkg;

  localparam int BYTE_W  = 8;
  localparam int MODE_W  = 2;
  localparam int INDEX_W = 6;
  localparam int LEN_W   = 7;
  localparam int HIT_W   = 24;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DATA  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

  localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

endpackage

// ----- src/fpsr_ram.sv -----
// Generic single write port RAM with one registered read port.
// Used for the replacement pattern store. No dependencies.
module fpsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/fixed_pattern_stream_replace_top.sv -----
// Top level of the fixed pattern stream replace block.
// Depends on fpsr_pkg and fpsr_ram.
//
// Replaces every leftmost, non-overlapping occurrence of a search pattern in a
// byte stream by an equally long replacement pattern. Mode 0 items load
// pattern byte pairs, mode 1 items carry data bytes, a mode 2 item flushes the
// held bytes unchanged and then gives one count-only result with the hit count.
// Load items and data bytes are taken one per cycle while the input is not
// stalled. A data byte that completes a match holds the input while the
// replacement bytes leave one per cycle through the output register, unless
// the output stalls, read one at a time from the replacement RAM; the overall
// rate stays one byte in per byte out. A flush emits the bytes held in the
// window one at a time and then the count result. A result waiting in the
// output register stalls the input until it transfers; in the cycle it
// transfers, the next item is taken.
module fixed_pattern_stream_replace_top #(
  parameter int MAX_PATTERN = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [fpsr_pkg::LEN_W-1:0]    cfg_wr_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [fpsr_pkg::MODE_W-1:0]   mode,
  input  logic [fpsr_pkg::INDEX_W-1:0]  pattern_index,
  input  logic [fpsr_pkg::BYTE_W-1:0]   search_byte,
  input  logic [fpsr_pkg::BYTE_W-1:0]   replace_byte,
  input  logic [fpsr_pkg::BYTE_W-1:0]   data_byte,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [fpsr_pkg::BYTE_W-1:0]   out_byte,
  output logic                          byte_valid,
  output logic                          replaced,
  output logic                          last,
  output logic [fpsr_pkg::HIT_W-1:0]    hit_count
);

  import fpsr_pkg::*;

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW    = $clog2(MAX_PATTERN + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_REPL  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  // configuration and control state
  logic [LEN_W-1:0]  pattern_length;
  logic [1:0]        state, state_next;
  logic [LW-1:0]     fill, fill_next;
  logic [LW-1:0]     rem, rem_next;
  logic [IDX_W-1:0]  rep_idx, rep_idx_next;
  logic [HIT_W-1:0]  hits, hits_next;

  // pattern and window storage
  logic [BYTE_W-1:0] search_store [MAX_PATTERN];
  logic [BYTE_W-1:0] window       [MAX_PATTERN];
  logic [BYTE_W-1:0] window_next  [MAX_PATTERN];
  logic [BYTE_W-1:0] lane         [MAX_PATTERN];

  logic [BYTE_W-1:0] byte_reg;
  logic [BYTE_W-1:0] ram_rdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic              ram_re;

  logic [LW-1:0]     len_eff;
  logic              enabled, full, match;
  logic              advance, item_accept, acc_load, acc_data, acc_flush, idx_ok;
  logic              push, pop, emit;
  logic [BYTE_W-1:0] e_byte;
  logic              e_bv, e_rep, e_last;
  logic [HIT_W-1:0]  e_hits;

  // effective length: zero disables matching but still moves one byte per byte
  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LW'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      len_eff = LW'(MAX_PATTERN);
    end else begin
      len_eff = LW'(pattern_length);
    end
  end

  assign enabled     = (pattern_length != '0);
  assign advance     = !result_valid || !result_stall;
  assign item_stall  = (state != ST_IDLE) || !advance;
  assign item_accept = item_valid && !item_stall;
  assign acc_load    = item_accept && (mode == MODE_LOAD);
  assign acc_data    = item_accept && (mode == MODE_DATA);
  assign acc_flush   = item_accept && (mode == MODE_FLUSH);
  assign idx_ok      = ({1'b0, pattern_index} < (INDEX_W + 1)'(MAX_PATTERN));

  // window plus the incoming byte reaches the pattern length
  assign full = ({1'b0, fill} + (LW + 1)'(1)) >= {1'b0, len_eff};

  // front compare: the incoming byte sits at position fill
  always_comb begin
    logic [BYTE_W-1:0] cand;
    match = enabled;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      cand = (LW'(k) == fill) ? data_byte : window[k];
      if ((LW'(k) < len_eff) && (cand != search_store[k])) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    push         = 1'b0;
    pop          = 1'b0;
    emit         = 1'b0;
    e_byte       = '0;
    e_bv         = 1'b0;
    e_rep        = 1'b0;
    e_last       = 1'b0;
    e_hits       = '0;
    ram_re       = 1'b0;
    ram_raddr    = rep_idx;
    state_next   = state;
    rem_next     = rem;
    rep_idx_next = rep_idx;
    hits_next    = hits;
    unique case (state)
      ST_IDLE: begin
        if (acc_data) begin
          push = 1'b1;
          if (full) begin
            pop  = 1'b1;
            emit = 1'b1;
            e_bv = 1'b1;
            if (match) begin
              e_rep     = 1'b1;
              ram_re    = 1'b1;
              ram_raddr = '0;
              e_last    = (len_eff == LW'(1));
              if (hits != HIT_MAX) begin
                hits_next = hits + HIT_W'(1);
              end
              if (!e_last) begin
                state_next   = ST_REPL;
                rem_next     = len_eff - LW'(1);
                rep_idx_next = IDX_W'(1);
              end
            end else begin
              e_byte = lane[0];
              e_last = 1'b1;
            end
          end
        end else if (acc_flush) begin
          state_next = ST_FLUSH;
        end
      end
      ST_REPL: begin
        // one window byte retires per replacement byte
        if (advance) begin
          pop          = 1'b1;
          emit         = 1'b1;
          e_bv         = 1'b1;
          e_rep        = 1'b1;
          ram_re       = 1'b1;
          e_last       = (rem == LW'(1));
          rem_next     = rem - LW'(1);
          rep_idx_next = rep_idx + IDX_W'(1);
          if (e_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (advance) begin
          emit = 1'b1;
          if (fill != '0) begin
            pop    = 1'b1;
            e_bv   = 1'b1;
            e_byte = window[0];
          end else begin
            e_last     = 1'b1;
            e_hits     = hits;
            hits_next  = '0;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // append at fill, then shift down by one on a pop
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      lane[j] = (push && (LW'(j) == fill)) ? data_byte : window[j];
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (pop && (i + 1 < MAX_PATTERN)) begin
        window_next[i] = lane[(i + 1 < MAX_PATTERN) ? i + 1 : i];
      end else begin
        window_next[i] = lane[i];
      end
    end
    fill_next = fill + LW'(push) - LW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_W'(1);
      state          <= ST_IDLE;
      fill           <= '0;
      rem            <= '0;
      rep_idx        <= '0;
      hits           <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pattern_length <= cfg_wr_data;
      end
      state   <= state_next;
      fill    <= fill_next;
      rem     <= rem_next;
      rep_idx <= rep_idx_next;
      hits    <= hits_next;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_load && idx_ok) begin
      search_store[pattern_index[IDX_W-1:0]] <= search_byte;
    end
    window <= window_next;
    if (emit) begin
      byte_reg   <= e_byte;
      byte_valid <= e_bv;
      replaced   <= e_rep;
      last       <= e_last;
      hit_count  <= e_hits;
    end
  end

  fpsr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PATTERN)
  ) u_replace_ram (
    .clk   (clk),
    .we    (acc_load && idx_ok),
    .waddr (pattern_index[IDX_W-1:0]),
    .wdata (replace_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // RAM read data holds while the output is stalled: reads only on emit
  assign out_byte = replaced ? ram_rdata : byte_reg;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill < LW'(MAX_PATTERN))
    else $error("window fill out of range");

  a_repl_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPL) |-> (rem != '0))
    else $error("replacement burst with nothing left");

  a_count_result: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !byte_valid) |-> (last && (fill == '0) && !replaced))
    else $error("count result with bytes still held");

  a_repl_end: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_REPL) && advance && (rem == LW'(1))) |=>
      ((state == ST_IDLE) && result_valid && last && replaced))
    else $error("replacement burst did not close");

endmodule
